FILE: hw/rtl/named_value_store_lru_defines.svh
// Assertion macros shared by the named value store.
`ifndef NAMED_VALUE_STORE_LRU_DEFINES_SVH
`define NAMED_VALUE_STORE_LRU_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NVS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nvs assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define NVS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nvs assertion failed");

`endif

FILE: hw/rtl/nvs_pkg.sv
// Types, codes and defaults of the named value store.
package nvs_pkg;
    localparam int NAME_W = 192;
    localparam int VAL_W = 64;
    localparam int CMD_W = 3;
    localparam int ST_W = 3;

    localparam int DEF_PERSIST_SLOTS = 64;
    localparam int DEF_TEMP_SLOTS = 32;
    localparam int DEF_NAME_BYTES = 24;

    localparam logic [CMD_W-1:0] CMD_GET = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SET = 3'd1;
    localparam logic [CMD_W-1:0] CMD_UNSET = 3'd2;
    localparam logic [CMD_W-1:0] CMD_UNSET_ALL = 3'd3;
    localparam logic [CMD_W-1:0] CMD_IS_DEF = 3'd4;

    localparam logic [ST_W-1:0] ST_OK = 3'd0;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd1;
    localparam logic [ST_W-1:0] ST_READ_ONLY = 3'd2;
    localparam logic [ST_W-1:0] ST_FWD_ARCH = 3'd3;
    localparam logic [ST_W-1:0] ST_FWD_SYMBOL = 3'd4;
    localparam logic [ST_W-1:0] ST_NO_SLOT = 3'd5;

    localparam logic [7:0] CH_TEMP = 8'h5F;
    localparam logic [7:0] CH_ARCH = 8'h24;
    localparam logic [7:0] CH_SYMBOL = 8'h40;

    typedef logic [NAME_W-1:0] name_t;
endpackage

FILE: hw/rtl/nvs_if.sv
// Request and response channel interfaces of the named value store.
interface nvs_req_if import nvs_pkg::*; ();
    logic valid;
    logic ready;
    logic [CMD_W-1:0] cmd;
    logic [63:0] name_word0;
    logic [63:0] name_word1;
    logic [63:0] name_word2;
    logic [VAL_W-1:0] new_value;
    logic [VAL_W-1:0] default_value;

    modport source (output valid, cmd, name_word0, name_word1, name_word2, new_value,
                    default_value, input ready);
    modport sink (input valid, cmd, name_word0, name_word1, name_word2, new_value,
                  default_value, output ready);
endinterface

interface nvs_rsp_if import nvs_pkg::*; ();
    logic valid;
    logic ready;
    logic [VAL_W-1:0] read_value;
    logic [ST_W-1:0] status;

    modport source (output valid, read_value, status, input ready);
    modport sink (input valid, read_value, status, output ready);
endinterface

FILE: hw/rtl/nvs_canon.sv
// Name canonicalizer: keeps the first NAME_BYTES-1 bytes up to the first zero byte.
module nvs_canon import nvs_pkg::*; #(
    parameter int NAME_BYTES = DEF_NAME_BYTES
) (
    input  logic [63:0] word0,
    input  logic [63:0] word1,
    input  logic [63:0] word2,
    output name_t       name
);
    logic [NAME_W-1:0] raw;

    assign raw = {word2, word1, word0};

    always_comb
    begin
        logic ended;
        logic [7:0] b;
        ended = 1'b0;
        name = '0;
        for (int i = 0; i < NAME_W / 8; i++)
        begin
            b = raw[i*8 +: 8];
            if (ended || (i + 1 >= NAME_BYTES))
            begin
                b = 8'd0;
            end
            if (b == 8'd0)
            begin
                ended = 1'b1;
            end
            name[i*8 +: 8] = b;
        end
    end
endmodule

FILE: hw/rtl/named_value_store_lru.sv
// Top level of the named value store with a persistent pool and an LRU temporary pool.
//
//   channel  role    contents
//   req      sink    cmd, name_word0..2, new_value, default_value
//   rsp      source  read_value, status
//
// A request that scans walks the pool that the name selects, slot by slot, and stops at the
// first hit; a miss walks the whole pool. An execute state then precedes the response.
// One shared 192-bit name compare walks the pool's name memory one slot per cycle.
// Commands that need no lookup go straight to the response state in the cycle after they are taken.
// Reset empties both pools at once through their used bits; names and values are not cleared.
// A response holds until taken, and no request is taken meanwhile.
`include "named_value_store_lru_defines.svh"
module named_value_store_lru import nvs_pkg::*; #(
    parameter int PERSIST_SLOTS = DEF_PERSIST_SLOTS,
    parameter int TEMP_SLOTS = DEF_TEMP_SLOTS,
    parameter int NAME_BYTES = DEF_NAME_BYTES
) (
    input logic clk,
    input logic rst_n,
    nvs_req_if.sink req,
    nvs_rsp_if.source rsp
);
    localparam int PW = (PERSIST_SLOTS > 1) ? $clog2(PERSIST_SLOTS) : 1;
    localparam int TW = (TEMP_SLOTS > 1) ? $clog2(TEMP_SLOTS) : 1;
    localparam int IW = (PW > TW) ? PW : TW;
    localparam logic [IW-1:0] P_LAST = IW'(PERSIST_SLOTS - 1);
    localparam logic [IW-1:0] T_LAST = IW'(TEMP_SLOTS - 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;
    localparam logic [1:0] S_RESP = 2'd3;

    logic [1:0] state_reg, state_next;
    logic [CMD_W-1:0] cmd_reg, cmd_next;
    name_t name_reg, name_next, canon_name;
    logic [VAL_W-1:0] nval_reg, nval_next;
    logic temp_reg, temp_next;
    logic [IW-1:0] cnt_reg, cnt_next;
    logic done_reg, done_next;
    logic pvld_reg, pvld_next;
    logic [IW-1:0] pidx_reg, pidx_next;
    logic found_reg, found_next;
    logic [IW-1:0] fidx_reg, fidx_next;
    logic [VAL_W-1:0] fval_reg, fval_next;
    logic free_reg, free_next;
    logic [IW-1:0] free_idx_reg, free_idx_next;
    logic old_reg, old_next;
    logic [IW-1:0] old_idx_reg, old_idx_next;
    logic [TW-1:0] old_rank_reg, old_rank_next;
    logic [VAL_W-1:0] out_value_reg, out_value_next;
    logic [ST_W-1:0] out_status_reg, out_status_next;

    logic p_used_reg [PERSIST_SLOTS];
    logic t_used_reg [TEMP_SLOTS];
    logic [TW-1:0] rec_reg [TEMP_SLOTS];

    name_t p_name_mem [PERSIST_SLOTS];
    logic [VAL_W-1:0] p_val_mem [PERSIST_SLOTS];
    name_t t_name_mem [TEMP_SLOTS];
    logic [VAL_W-1:0] t_val_mem [TEMP_SLOTS];
    name_t p_rname_reg, t_rname_reg;
    logic [VAL_W-1:0] p_rval_reg, t_rval_reg;

    logic [7:0] canon_first, first;
    logic [IW-1:0] last, target;
    logic cmp_used, hit, accept;
    logic [TW-1:0] cmp_rank;
    name_t rd_name;
    logic [VAL_W-1:0] rd_val;
    logic clear_all, wr_name, wr_val, set_used, clr_used, do_touch, do_insert, do_remove;

    nvs_canon #(.NAME_BYTES(NAME_BYTES)) u_canon (
        .word0(req.name_word0),
        .word1(req.name_word1),
        .word2(req.name_word2),
        .name (canon_name)
    );

    assign canon_first = canon_name[7:0];
    assign first = name_reg[7:0];
    assign accept = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = (state_reg == S_RESP);
    assign rsp.read_value = out_value_reg;
    assign rsp.status = out_status_reg;

    assign last = temp_reg ? T_LAST : P_LAST;
    assign cmp_used = temp_reg ? t_used_reg[pidx_reg[TW-1:0]] : p_used_reg[pidx_reg[PW-1:0]];
    assign cmp_rank = rec_reg[pidx_reg[TW-1:0]];
    assign rd_name = temp_reg ? t_rname_reg : p_rname_reg;
    assign rd_val = temp_reg ? t_rval_reg : p_rval_reg;
    assign hit = pvld_reg && cmp_used && (rd_name == name_reg);
    assign target = found_reg ? fidx_reg : (free_reg ? free_idx_reg : old_idx_reg);

    always_comb
    begin
        state_next = state_reg;
        cmd_next = cmd_reg;
        name_next = name_reg;
        nval_next = nval_reg;
        temp_next = temp_reg;
        cnt_next = cnt_reg;
        done_next = done_reg;
        pvld_next = pvld_reg;
        pidx_next = pidx_reg;
        found_next = found_reg;
        fidx_next = fidx_reg;
        fval_next = fval_reg;
        free_next = free_reg;
        free_idx_next = free_idx_reg;
        old_next = old_reg;
        old_idx_next = old_idx_reg;
        old_rank_next = old_rank_reg;
        out_value_next = out_value_reg;
        out_status_next = out_status_reg;
        clear_all = 1'b0;
        wr_name = 1'b0;
        wr_val = 1'b0;
        set_used = 1'b0;
        clr_used = 1'b0;
        do_touch = 1'b0;
        do_insert = 1'b0;
        do_remove = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next = req.cmd;
                    name_next = canon_name;
                    nval_next = req.new_value;
                    temp_next = (canon_first == CH_TEMP);
                    out_value_next = req.default_value;
                    out_status_next = ST_OK;
                    cnt_next = '0;
                    done_next = 1'b0;
                    pvld_next = 1'b0;
                    found_next = 1'b0;
                    free_next = 1'b0;
                    old_next = 1'b0;
                    if (req.cmd == CMD_UNSET_ALL)
                    begin
                        clear_all = 1'b1;
                        state_next = S_RESP;
                    end
                    else if (req.cmd == CMD_SET && canon_first == CH_SYMBOL)
                    begin
                        out_status_next = ST_READ_ONLY;
                        state_next = S_RESP;
                    end
                    else if (req.cmd == CMD_SET && canon_first == CH_ARCH)
                    begin
                        out_status_next = ST_FWD_ARCH;
                        state_next = S_RESP;
                    end
                    else if (req.cmd inside {CMD_GET, CMD_SET, CMD_UNSET, CMD_IS_DEF})
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_RESP;
                    end
                end
            end
            S_SCAN:
            begin
                pvld_next = !done_reg;
                pidx_next = cnt_reg;
                if (!done_reg)
                begin
                    if (cnt_reg == last)
                    begin
                        done_next = 1'b1;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                if (hit)
                begin
                    found_next = 1'b1;
                    fidx_next = pidx_reg;
                    fval_next = rd_val;
                    state_next = S_EXEC;
                end
                else if (pvld_reg)
                begin
                    if (!cmp_used && !free_reg)
                    begin
                        free_next = 1'b1;
                        free_idx_next = pidx_reg;
                    end
                    if (cmp_used && (!old_reg || cmp_rank > old_rank_reg))
                    begin
                        old_next = 1'b1;
                        old_idx_next = pidx_reg;
                        old_rank_next = cmp_rank;
                    end
                    if (pidx_reg == last)
                    begin
                        state_next = S_EXEC;
                    end
                end
            end
            S_EXEC:
            begin
                state_next = S_RESP;
                case (cmd_reg)
                    CMD_GET, CMD_IS_DEF:
                    begin
                        if (found_reg)
                        begin
                            if (cmd_reg == CMD_GET)
                            begin
                                out_value_next = fval_reg;
                                do_touch = temp_reg;
                            end
                        end
                        else if (first == CH_ARCH)
                        begin
                            out_status_next = ST_FWD_ARCH;
                        end
                        else if (first == CH_SYMBOL)
                        begin
                            out_status_next = ST_FWD_SYMBOL;
                        end
                        else
                        begin
                            out_status_next = ST_NOT_FOUND;
                        end
                    end
                    CMD_SET:
                    begin
                        if (found_reg)
                        begin
                            wr_val = 1'b1;
                            do_touch = temp_reg;
                        end
                        else if (free_reg || (temp_reg && old_reg))
                        begin
                            if (first != 8'd0)
                            begin
                                wr_name = 1'b1;
                                wr_val = 1'b1;
                                set_used = 1'b1;
                                do_insert = temp_reg;
                            end
                        end
                        else
                        begin
                            out_status_next = ST_NO_SLOT;
                        end
                    end
                    CMD_UNSET:
                    begin
                        if (found_reg)
                        begin
                            clr_used = 1'b1;
                            do_remove = temp_reg;
                        end
                        else
                        begin
                            out_status_next = ST_NOT_FOUND;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_RESP:
            begin
                if (rsp.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg <= 1'b0;
            pvld_reg <= 1'b0;
            found_reg <= 1'b0;
            free_reg <= 1'b0;
            old_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg <= done_next;
            pvld_reg <= pvld_next;
            found_reg <= found_next;
            free_reg <= free_next;
            old_reg <= old_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        name_reg <= name_next;
        nval_reg <= nval_next;
        temp_reg <= temp_next;
        cnt_reg <= cnt_next;
        pidx_reg <= pidx_next;
        fidx_reg <= fidx_next;
        fval_reg <= fval_next;
        free_idx_reg <= free_idx_next;
        old_idx_reg <= old_idx_next;
        old_rank_reg <= old_rank_next;
        out_value_reg <= out_value_next;
        out_status_reg <= out_status_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < PERSIST_SLOTS; j++)
            begin
                p_used_reg[j] <= 1'b0;
            end
            for (int j = 0; j < TEMP_SLOTS; j++)
            begin
                t_used_reg[j] <= 1'b0;
                rec_reg[j] <= '0;
            end
        end
        else if (clear_all)
        begin
            for (int j = 0; j < PERSIST_SLOTS; j++)
            begin
                p_used_reg[j] <= 1'b0;
            end
            for (int j = 0; j < TEMP_SLOTS; j++)
            begin
                t_used_reg[j] <= 1'b0;
                rec_reg[j] <= '0;
            end
        end
        else
        begin
            if (set_used || clr_used)
            begin
                if (temp_reg)
                begin
                    t_used_reg[target[TW-1:0]] <= set_used;
                end
                else
                begin
                    p_used_reg[target[PW-1:0]] <= set_used;
                end
            end
            for (int j = 0; j < TEMP_SLOTS; j++)
            begin
                if (j == int'(target[TW-1:0]))
                begin
                    if (do_touch || do_insert)
                    begin
                        rec_reg[j] <= '0;
                    end
                end
                else if (t_used_reg[j])
                begin
                    if (do_insert)
                    begin
                        rec_reg[j] <= rec_reg[j] + 1'b1;
                    end
                    else if (do_touch && rec_reg[j] < rec_reg[target[TW-1:0]])
                    begin
                        rec_reg[j] <= rec_reg[j] + 1'b1;
                    end
                    else if (do_remove && rec_reg[j] > rec_reg[target[TW-1:0]])
                    begin
                        rec_reg[j] <= rec_reg[j] - 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_name && !temp_reg)
        begin
            p_name_mem[target[PW-1:0]] <= name_reg;
        end
        if (wr_val && !temp_reg)
        begin
            p_val_mem[target[PW-1:0]] <= nval_reg;
        end
        p_rname_reg <= p_name_mem[cnt_reg[PW-1:0]];
        p_rval_reg <= p_val_mem[cnt_reg[PW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (wr_name && temp_reg)
        begin
            t_name_mem[target[TW-1:0]] <= name_reg;
        end
        if (wr_val && temp_reg)
        begin
            t_val_mem[target[TW-1:0]] <= nval_reg;
        end
        t_rname_reg <= t_name_mem[cnt_reg[TW-1:0]];
        t_rval_reg <= t_val_mem[cnt_reg[TW-1:0]];
    end

    `NVS_ASSERT_SAME(a_ready_excl_resp, req.ready, !rsp.valid)
    `NVS_ASSERT_NEXT(a_busy_after_req, accept, !req.ready)
    `NVS_ASSERT_NEXT(a_idle_after_resp, rsp.valid && rsp.ready, req.ready)
endmodule

FILE: bench/tb.sv
// Self-checking testbench for the named value store with LRU temporary pool.
module tb;
    import nvs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int P_SLOTS = DEF_PERSIST_SLOTS;
    localparam int T_SLOTS = DEF_TEMP_SLOTS;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic [ST_W-1:0] status;
    } answer_t;

    logic clk;
    logic rst_n;
    int errors;
    int send_idle_pct;
    int recv_stall_pct;

    nvs_req_if req ();
    nvs_rsp_if rsp ();

    named_value_store_lru dut (
        .clk(clk),
        .rst_n(rst_n),
        .req(req),
        .rsp(rsp)
    );

    logic p_used [P_SLOTS];
    logic [NAME_W-1:0] p_name [P_SLOTS];
    logic [VAL_W-1:0] p_val [P_SLOTS];
    logic t_used [T_SLOTS];
    logic [NAME_W-1:0] t_name [T_SLOTS];
    logic [VAL_W-1:0] t_val [T_SLOTS];
    int t_rank [T_SLOTS];

    answer_t pending_answers[$];
    logic [NAME_W-1:0] name_pool[$];

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #100ms;
        $display("named_value_store_lru test failed");
        $finish;
    end

    function automatic logic [NAME_W-1:0] trim_name(input logic [NAME_W-1:0] raw);
        logic [NAME_W-1:0] w;
        logic ended;
        logic [7:0] b;
        w = '0;
        ended = 1'b0;
        for (int i = 0; i < 24; i++)
        begin
            b = raw[8*i +: 8];
            if (ended || i + 1 >= DEF_NAME_BYTES)
                b = 8'h00;
            if (b == 8'h00)
                ended = 1'b1;
            w[8*i +: 8] = b;
        end
        return w;
    endfunction

    function automatic int find_slot(input logic is_temp, input logic [NAME_W-1:0] w);
        if (is_temp)
        begin
            for (int i = 0; i < T_SLOTS; i++)
                if (t_used[i] && t_name[i] == w)
                    return i;
        end
        else
        begin
            for (int i = 0; i < P_SLOTS; i++)
                if (p_used[i] && p_name[i] == w)
                    return i;
        end
        return -1;
    endfunction

    function automatic void rank_touch(input int s);
        int r;
        r = t_rank[s];
        for (int j = 0; j < T_SLOTS; j++)
            if (j != s && t_used[j] && t_rank[j] < r)
                t_rank[j]++;
        t_rank[s] = 0;
    endfunction

    function automatic void rank_remove(input int s);
        for (int j = 0; j < T_SLOTS; j++)
            if (j != s && t_used[j] && t_rank[j] > t_rank[s])
                t_rank[j]--;
    endfunction

    function automatic logic [ST_W-1:0] miss_code(input logic [7:0] first);
        if (first == CH_ARCH)
            return ST_FWD_ARCH;
        if (first == CH_SYMBOL)
            return ST_FWD_SYMBOL;
        return ST_NOT_FOUND;
    endfunction

    function automatic answer_t store_step(input logic [CMD_W-1:0] cmd,
                                           input logic [NAME_W-1:0] raw,
                                           input logic [VAL_W-1:0] nv,
                                           input logic [VAL_W-1:0] dv);
        answer_t a;
        logic [NAME_W-1:0] w;
        logic [7:0] first;
        logic is_temp;
        int idx;
        w = trim_name(raw);
        first = w[7:0];
        is_temp = (first == CH_TEMP);
        a.value = dv;
        a.status = ST_OK;
        if (cmd == CMD_GET || cmd == CMD_IS_DEF)
        begin
            idx = find_slot(is_temp, w);
            if (idx < 0)
                a.status = miss_code(first);
            else if (cmd == CMD_GET)
            begin
                a.value = is_temp ? t_val[idx] : p_val[idx];
                if (is_temp)
                    rank_touch(idx);
            end
        end
        else if (cmd == CMD_SET)
        begin
            if (first == CH_SYMBOL)
                a.status = ST_READ_ONLY;
            else if (first == CH_ARCH)
                a.status = ST_FWD_ARCH;
            else
            begin
                idx = find_slot(is_temp, w);
                if (idx >= 0)
                begin
                    if (is_temp)
                    begin
                        t_val[idx] = nv;
                        rank_touch(idx);
                    end
                    else
                        p_val[idx] = nv;
                end
                else
                begin
                    if (is_temp)
                    begin
                        for (int i = T_SLOTS - 1; i >= 0; i--)
                            if (!t_used[i])
                                idx = i;
                        if (idx < 0)
                        begin
                            for (int j = 0; j < T_SLOTS; j++)
                                if (t_used[j] && (idx < 0 || t_rank[j] > t_rank[idx]))
                                    idx = j;
                            rank_remove(idx);
                            t_used[idx] = 1'b0;
                        end
                        t_name[idx] = w;
                        t_val[idx] = nv;
                        for (int j = 0; j < T_SLOTS; j++)
                            if (j != idx && t_used[j])
                                t_rank[j]++;
                        t_rank[idx] = 0;
                        t_used[idx] = 1'b1;
                    end
                    else
                    begin
                        for (int i = P_SLOTS - 1; i >= 0; i--)
                            if (!p_used[i])
                                idx = i;
                        if (idx < 0)
                            a.status = ST_NO_SLOT;
                        else if (first != 8'h00)
                        begin
                            p_name[idx] = w;
                            p_val[idx] = nv;
                            p_used[idx] = 1'b1;
                        end
                    end
                end
            end
        end
        else if (cmd == CMD_UNSET)
        begin
            idx = find_slot(is_temp, w);
            if (idx < 0)
                a.status = ST_NOT_FOUND;
            else if (is_temp)
            begin
                rank_remove(idx);
                t_used[idx] = 1'b0;
            end
            else
                p_used[idx] = 1'b0;
        end
        else if (cmd == CMD_UNSET_ALL)
        begin
            for (int i = 0; i < P_SLOTS; i++)
                p_used[i] = 1'b0;
            for (int i = 0; i < T_SLOTS; i++)
            begin
                t_used[i] = 1'b0;
                t_rank[i] = 0;
            end
        end
        return a;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        errors++;
        $display("ERROR %0t: %s got %h expected %h", $realtime, what, got, want);
    endtask

    // Valid stays up after an accepted request until the next request or an idle cycle
    // replaces it; the block is busy in between, so the old request is never taken twice.
    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [NAME_W-1:0] raw,
                                input logic [VAL_W-1:0] nv, input logic [VAL_W-1:0] dv);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        pending_answers.push_back(store_step(cmd, raw, nv, dv));
        req.valid <= 1'b1;
        req.cmd <= cmd;
        req.name_word0 <= raw[63:0];
        req.name_word1 <= raw[127:64];
        req.name_word2 <= raw[191:128];
        req.new_value <= nv;
        req.default_value <= dv;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (pending_answers.size() == 0)
                report_mismatch("unexpected response status", 64'(rsp.status), 64'hx);
            else
            begin
                want = pending_answers.pop_front();
                if (rsp.status !== want.status)
                    report_mismatch("status", 64'(rsp.status), 64'(want.status));
                if (rsp.read_value !== want.value)
                    report_mismatch("read_value", rsp.read_value, want.value);
            end
        end
        if (rst_n)
            rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic logic [NAME_W-1:0] make_name(input logic [7:0] lead, input int len);
        logic [NAME_W-1:0] n;
        n = '0;
        n[7:0] = lead;
        for (int i = 1; i < len && i < 24; i++)
            n[8*i +: 8] = 8'($urandom_range(1, 255));
        return n;
    endfunction

    function automatic logic [NAME_W-1:0] pick_name();
        int k;
        logic [NAME_W-1:0] n;
        k = $urandom_range(99);
        if (k < 8)
            return {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
        if (k < 55 && name_pool.size() > 0)
            return name_pool[$urandom_range(name_pool.size() - 1)];
        case ($urandom_range(9))
            0: n = make_name(CH_ARCH, $urandom_range(1, 6));
            1: n = make_name(CH_SYMBOL, $urandom_range(1, 6));
            2, 3, 4: n = make_name(CH_TEMP, $urandom_range(1, 5));
            default: n = make_name(8'($urandom_range(1, 255)), $urandom_range(1, 24));
        endcase
        if (name_pool.size() < 140)
            name_pool.push_back(n);
        return n;
    endfunction

    task automatic wait_drained();
        req.valid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed();
        logic [NAME_W-1:0] full;
        full = '1;
        send_request(CMD_GET, make_name(8'h41, 3), 64'h0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(CMD_SET, full, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
        send_request(CMD_GET, full ^ {8'hAA, 184'h0}, 64'h0, 64'h1234);
        send_request(CMD_IS_DEF, full, 64'h0, 64'h5);
        send_request(CMD_SET, '0, 64'h77, 64'h9);
        send_request(CMD_GET, '0, 64'h0, 64'h9);
        send_request(CMD_SET, make_name(CH_SYMBOL, 4), 64'h1, 64'h2);
        send_request(CMD_GET, make_name(CH_SYMBOL, 4), 64'h1, 64'h2);
        send_request(CMD_SET, make_name(CH_ARCH, 3), 64'h1, 64'h3);
        send_request(CMD_IS_DEF, make_name(CH_ARCH, 3), 64'h1, 64'h3);
        send_request(CMD_UNSET, make_name(8'h42, 2), 64'h0, 64'h4);
        send_request(CMD_UNSET, full, 64'h0, 64'h4);
        send_request(CMD_SET, {184'h0, CH_TEMP}, 64'hABCD, 64'h0);
        send_request(CMD_GET, {184'h0, CH_TEMP}, 64'h0, 64'h0);
        send_request(3'd5, full, 64'h1, 64'h6);
        send_request(3'd7, '0, 64'h1, 64'h7);
        send_request(CMD_UNSET_ALL, '0, 64'h0, 64'h8);
        send_request(CMD_GET, {184'h0, CH_TEMP}, 64'h0, 64'hC);
    endtask

    task automatic test_pool_limits();
        for (int i = 0; i < P_SLOTS + 2; i++)
            send_request(CMD_SET, make_name(8'($urandom_range(1, 90)), 8), {$urandom(), $urandom()},
                         64'h0);
        send_request(CMD_SET, '0, 64'h0, 64'h0);
        for (int i = 0; i < T_SLOTS + 6; i++)
            send_request(CMD_SET, {168'h0, 8'(i), 8'h01, CH_TEMP}, 64'(i), 64'h0);
        for (int i = 0; i < T_SLOTS + 6; i++)
            send_request(CMD_GET, {168'h0, 8'(i), 8'h01, CH_TEMP}, 64'h0, 64'hDEAD);
        wait_drained();
        send_request(CMD_UNSET_ALL, '0, 64'h0, 64'h0);
    endtask

    task automatic test_random(input int count);
        int k;
        logic [CMD_W-1:0] cmd;
        for (int i = 0; i < count; i++)
        begin
            k = $urandom_range(99);
            if (k < 30)
                cmd = CMD_SET;
            else if (k < 60)
                cmd = CMD_GET;
            else if (k < 75)
                cmd = CMD_IS_DEF;
            else if (k < 92)
                cmd = CMD_UNSET;
            else if (k < 94)
                cmd = CMD_UNSET_ALL;
            else
                cmd = 3'($urandom_range(5, 7));
            send_request(cmd, pick_name(), {$urandom(), $urandom()}, {$urandom(), $urandom()});
        end
    endtask

    initial
    begin
        errors = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.cmd = '0;
        req.name_word0 = '0;
        req.name_word1 = '0;
        req.name_word2 = '0;
        req.new_value = '0;
        req.default_value = '0;
        rsp.ready = 1'b0;
        for (int i = 0; i < P_SLOTS; i++)
            p_used[i] = 1'b0;
        for (int i = 0; i < T_SLOTS; i++)
        begin
            t_used[i] = 1'b0;
            t_rank[i] = 0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_pool_limits();
        test_random(250);
        send_idle_pct = 55;
        test_random(250);
        wait_drained();
        send_idle_pct = 0;
        recv_stall_pct = 55;
        test_random(250);
        send_idle_pct = 12;
        recv_stall_pct = 12;
        test_random(250);
        wait_drained();
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("named_value_store_lru test passed");
        else
            $display("named_value_store_lru test failed");
        $finish;
    end
endmodule
